[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the checker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on clk, disabled during reset
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication on clk, disabled during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/lpbm_pkg.sv]
// ----------------------------------------------------------------------------
// lpbm_pkg
// types and constants of the lru page buffer manager
// ----------------------------------------------------------------------------
package lpbm_pkg;

    localparam int SLOTS      = 4;
    localparam int PAGE_COUNT = 333;

    localparam int KEY_W       = 16;
    localparam int CMD_W       = 1;
    localparam int HIT_SLOT_W  = 2;
    localparam int PAGE_FLD_W  = 9;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int KEY_MAX = (1 << KEY_W) - 1;
    localparam int QUOT_W  = $clog2(KEY_MAX / PAGE_COUNT + 1);

    // exact quotient for every key: floor(key * RECIP / 2^RECIP_SHIFT)
    localparam int RECIP_SHIFT = KEY_W + $clog2(PAGE_COUNT);
    localparam int RECIP_W     = KEY_W + 1;
    localparam longint RECIP   = ((longint'(1) << RECIP_SHIFT) + PAGE_COUNT - 1) / PAGE_COUNT;
    localparam int PROD_W      = KEY_W + RECIP_W;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_MODIFY = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] record_key;
    } req_t;

    typedef struct packed {
        logic                  hit;
        logic [HIT_SLOT_W-1:0] hit_slot;
        logic                  writeback;
        logic [PAGE_FLD_W-1:0] writeback_page;
        logic [PAGE_FLD_W-1:0] front_page;
    } rsp_t;

endpackage

[rtl/lru_page_buffer_manager.sv]
// ----------------------------------------------------------------------------
// lru_page_buffer_manager
// Four-slot page buffer in move-to-front order. Each request key is reduced
// modulo the page count and looked up in all slots at once; a hit moves the
// slot to the front, a miss installs the page clean at the front and reports
// a writeback when the evicted last slot was dirty, and a modify marks the
// front page dirty. One request is taken every cycle unless the response is
// stalled; the response is registered after the input stage: that stage forms
// the quotient of the key by the page count with a constant reciprocal
// multiply, the next stage finishes the remainder, compares the slots and
// updates them while loading the response register. A stalled response holds
// the whole pipeline and shows as stall on the request side in the same cycle.
// ----------------------------------------------------------------------------
module lru_page_buffer_manager
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  lpbm_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output lpbm_pkg::rsp_t rsp_data
);

    logic                              advance;
    logic [lpbm_pkg::PROD_W-1:0]       quot_prod;
    logic [lpbm_pkg::QUOT_W-1:0]       quot;

    logic                              s1_valid_reg;
    logic                              s1_cmd_reg;
    logic [lpbm_pkg::KEY_W-1:0]        s1_key_reg;
    logic [lpbm_pkg::QUOT_W-1:0]       s1_quot_reg;

    logic [lpbm_pkg::PAGE_W-1:0]       slot_page_reg  [lpbm_pkg::SLOTS];
    logic [lpbm_pkg::PAGE_W-1:0]       slot_page_next [lpbm_pkg::SLOTS];
    logic [lpbm_pkg::SLOTS-1:0]        slot_valid_reg;
    logic [lpbm_pkg::SLOTS-1:0]        slot_valid_next;
    logic [lpbm_pkg::SLOTS-1:0]        slot_dirty_reg;
    logic [lpbm_pkg::SLOTS-1:0]        slot_dirty_next;

    logic [lpbm_pkg::KEY_W-1:0]        quot_mul;
    logic [lpbm_pkg::KEY_W-1:0]        rem;
    logic [lpbm_pkg::PAGE_W-1:0]       page;
    logic [lpbm_pkg::SLOTS-1:0]        match;
    logic                              hit;
    logic [lpbm_pkg::SLOT_W-1:0]       found_idx;
    logic                              wb;

    logic                              rsp_valid_reg;
    lpbm_pkg::rsp_t                    rsp_reg;
    lpbm_pkg::rsp_t                    rsp_next;

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !advance;

    assign quot_prod = lpbm_pkg::PROD_W'(req_data.record_key)
                     * lpbm_pkg::PROD_W'(lpbm_pkg::RECIP);
    assign quot      = lpbm_pkg::QUOT_W'(quot_prod >> lpbm_pkg::RECIP_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && req_valid)
        begin
            s1_cmd_reg  <= req_data.cmd;
            s1_key_reg  <= req_data.record_key;
            s1_quot_reg <= quot;
        end
    end

    always_comb
    begin
        quot_mul = lpbm_pkg::KEY_W'(lpbm_pkg::KEY_W'(s1_quot_reg)
                 * lpbm_pkg::KEY_W'(lpbm_pkg::PAGE_COUNT));
        rem      = s1_key_reg - quot_mul;
        page     = lpbm_pkg::PAGE_W'(rem);

        for (int i = 0; i < lpbm_pkg::SLOTS; i++)
        begin
            match[i] = slot_valid_reg[i] && (slot_page_reg[i] == page);
        end

        hit       = |match;
        found_idx = '0;
        for (int i = lpbm_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                found_idx = lpbm_pkg::SLOT_W'(i);
            end
        end

        wb = !hit && slot_valid_reg[lpbm_pkg::SLOTS-1] && slot_dirty_reg[lpbm_pkg::SLOTS-1];

        for (int i = 1; i < lpbm_pkg::SLOTS; i++)
        begin
            if (!hit || (lpbm_pkg::SLOT_W'(i) <= found_idx))
            begin
                slot_page_next[i]  = slot_page_reg[i-1];
                slot_valid_next[i] = slot_valid_reg[i-1];
                slot_dirty_next[i] = slot_dirty_reg[i-1];
            end
            else
            begin
                slot_page_next[i]  = slot_page_reg[i];
                slot_valid_next[i] = slot_valid_reg[i];
                slot_dirty_next[i] = slot_dirty_reg[i];
            end
        end
        slot_page_next[0]  = page;
        slot_valid_next[0] = 1'b1;
        slot_dirty_next[0] = (hit && slot_dirty_reg[found_idx])
                          || (s1_cmd_reg == lpbm_pkg::CMD_MODIFY);

        rsp_next.hit            = hit;
        rsp_next.hit_slot       = hit ? lpbm_pkg::HIT_SLOT_W'(found_idx) : '0;
        rsp_next.writeback      = wb;
        rsp_next.writeback_page = wb ? lpbm_pkg::PAGE_FLD_W'(slot_page_reg[lpbm_pkg::SLOTS-1])
                                     : '0;
        rsp_next.front_page     = lpbm_pkg::PAGE_FLD_W'(page);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            slot_dirty_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                slot_valid_reg <= slot_valid_next;
                slot_dirty_reg <= slot_dirty_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            slot_page_reg <= slot_page_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

[rtl/lpbm_checker.sv]
// ----------------------------------------------------------------------------
// lpbm_checker
// port-level checks of the lru page buffer manager, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpbm_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input lpbm_pkg::req_t req_data,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input lpbm_pkg::rsp_t rsp_data
);

    // a writeback only comes from a miss
    `ASSERT_IMPLY(a_wb_on_miss, rsp_valid && rsp_data.writeback, !rsp_data.hit)

    // miss reports slot zero
    `ASSERT_IMPLY(a_miss_slot, rsp_valid && !rsp_data.hit, rsp_data.hit_slot == '0)

    // no writeback page without a writeback
    `ASSERT_IMPLY(a_wb_page, rsp_valid && !rsp_data.writeback, rsp_data.writeback_page == '0)

    // a stalled response transfer holds
    `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

    // a stalled request transfer holds
    `ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_data))

endmodule

bind lru_page_buffer_manager lpbm_checker u_lpbm_checker (.*);
